/* hw/rtl/cdp_pkg.sv */
// Shared constants, types and state encodings for the counter delta permille block.
`timescale 1ns / 1ps
`default_nettype none
package cdp_pkg;

    localparam int NUM_STATES = 5;
    localparam int NUM_CPUS   = 8;

    localparam int CPU_W   = 3;
    localparam int ST_W    = 3;
    localparam int CNT_W   = 64;
    localparam int PERM_W  = 10;
    localparam int CMP_W   = 8;

    localparam int SLOT_N  = NUM_CPUS * NUM_STATES;
    localparam int SLOT_W  = $clog2(SLOT_N);

    localparam int SCALE     = 1000;
    localparam int DIV_STEPS = PERM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int REM_W     = CNT_W + PERM_W + 1;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [ST_W-1:0] LAST_ST = ST_W'(NUM_STATES - 1);

    // One classified sample handed from the front to the back.
    typedef struct packed {
        logic [CPU_W-1:0] cpu;
        logic [ST_W-1:0]  st;
        logic [CNT_W-1:0] diff;
        logic [CNT_W-1:0] total;
        logic             close;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_READ,
        FE_PUSH
    } t_fe_state;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_MUL,
        BE_ADD,
        BE_DIV,
        BE_OUT
    } t_be_state;

endpackage
`default_nettype wire

/* hw/rtl/cdp_queue.sv */
// Short queue of classified samples between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module cdp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire cdp_pkg::t_entry i_entry,
    input  wire logic          i_pop,
    output cdp_pkg::t_entry    o_head,
    output cdp_pkg::t_q_stat   o_stat
);

    cdp_pkg::t_entry                  r_mem [cdp_pkg::QDEPTH];
    logic [cdp_pkg::QPTR_W-1:0]       r_wptr;
    logic [cdp_pkg::QPTR_W-1:0]       r_rptr;
    logic [cdp_pkg::QCNT_W-1:0]       r_count;
    logic                             w_push;
    logic                             w_pop;

    assign o_stat.full  = (r_count == cdp_pkg::QCNT_W'(cdp_pkg::QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/cdp_front.sv */
// Front end: accept samples, difference them against the stored counts, keep the run total.
`timescale 1ns / 1ps
`default_nettype none
module cdp_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [cdp_pkg::CPU_W-1:0]     i_cpu_index,
    input  wire logic [cdp_pkg::ST_W-1:0]      i_state_index,
    input  wire logic [cdp_pkg::CNT_W-1:0]     i_count_value,
    input  wire cdp_pkg::t_q_stat              i_q_stat,
    output logic                               o_push,
    output cdp_pkg::t_entry                    o_entry
);

    cdp_pkg::t_fe_state                r_state;
    cdp_pkg::t_fe_state                n_state;

    logic [cdp_pkg::CNT_W-1:0]         r_prev_mem [cdp_pkg::SLOT_N];
    logic [cdp_pkg::SLOT_N-1:0]        r_prev_vld;
    logic [cdp_pkg::CNT_W-1:0]         r_rdata;
    logic                              r_rvld;

    logic [cdp_pkg::CPU_W-1:0]         r_cpu;
    logic [cdp_pkg::ST_W-1:0]          r_st;
    logic [cdp_pkg::CNT_W-1:0]         r_val;
    logic [cdp_pkg::SLOT_W-1:0]        r_slot;
    logic                              r_ok;
    logic [cdp_pkg::CNT_W-1:0]         r_total;
    cdp_pkg::t_entry                   r_entry;

    logic                              w_accept;
    logic                              w_in_range;
    logic [cdp_pkg::SLOT_W-1:0]        w_slot;
    logic [cdp_pkg::CNT_W-1:0]         w_diff;
    logic [cdp_pkg::CNT_W-1:0]         w_total;
    logic                              w_upd;

    assign w_in_range = (cdp_pkg::CMP_W'(i_cpu_index) < cdp_pkg::CMP_W'(cdp_pkg::NUM_CPUS))
                     && (cdp_pkg::CMP_W'(i_state_index) < cdp_pkg::CMP_W'(cdp_pkg::NUM_STATES));
    assign w_slot = w_in_range
        ? (cdp_pkg::SLOT_W'(i_cpu_index) * cdp_pkg::SLOT_W'(cdp_pkg::NUM_STATES)
           + cdp_pkg::SLOT_W'(i_state_index))
        : '0;

    // Unwritten slots read as zero.
    assign w_diff  = r_val - (r_rvld ? r_rdata : '0);
    assign w_total = (r_st == '0) ? w_diff : (r_total + w_diff);
    assign w_upd   = (r_state == cdp_pkg::FE_READ) && r_ok;

    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdp_pkg::FE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_push     = 1'b0;
        w_accept   = 1'b0;
        unique case (r_state)
            cdp_pkg::FE_IDLE: begin
                o_in_stall = 1'b0;
                w_accept   = i_in_valid;
                if (i_in_valid) begin
                    n_state = cdp_pkg::FE_READ;
                end
            end
            cdp_pkg::FE_READ: begin
                // Drop out-of-range samples here.
                n_state = r_ok ? cdp_pkg::FE_PUSH : cdp_pkg::FE_IDLE;
            end
            cdp_pkg::FE_PUSH: begin
                if (!i_q_stat.full) begin
                    o_push  = 1'b1;
                    n_state = cdp_pkg::FE_IDLE;
                end
            end
            default: begin
                n_state = cdp_pkg::FE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_vld <= '0;
            r_total    <= '0;
        end else if (w_upd) begin
            r_prev_vld[r_slot] <= 1'b1;
            r_total            <= w_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rdata <= r_prev_mem[w_slot];
            r_rvld  <= r_prev_vld[w_slot];
            r_cpu   <= i_cpu_index;
            r_st    <= i_state_index;
            r_val   <= i_count_value;
            r_slot  <= w_slot;
            r_ok    <= w_in_range;
        end
        if (w_upd) begin
            r_prev_mem[r_slot] <= r_val;
            r_entry.cpu        <= r_cpu;
            r_entry.st         <= r_st;
            r_entry.diff       <= w_diff;
            r_entry.total      <= w_total;
            r_entry.close      <= (r_st == cdp_pkg::LAST_ST);
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/cdp_back.sv */
// Back end: hold the per-state deltas and compute each share with a shift-subtract divider.
`timescale 1ns / 1ps
`default_nettype none
module cdp_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cdp_pkg::t_q_stat              i_q_stat,
    input  wire cdp_pkg::t_entry               i_head,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [cdp_pkg::CPU_W-1:0]          o_out_cpu,
    output logic [cdp_pkg::ST_W-1:0]           o_out_state,
    output logic [cdp_pkg::PERM_W-1:0]         o_permille,
    output logic                               o_last
);

    cdp_pkg::t_be_state                r_state;
    cdp_pkg::t_be_state                n_state;

    logic [cdp_pkg::CNT_W-1:0]         r_deltas [cdp_pkg::NUM_STATES];
    logic [cdp_pkg::CNT_W-1:0]         r_total;
    logic [cdp_pkg::CPU_W-1:0]         r_cpu;
    logic [cdp_pkg::ST_W-1:0]          r_k;
    logic                              r_sat;
    logic [cdp_pkg::REM_W-1:0]         r_rem;
    logic [cdp_pkg::REM_W-1:0]         r_div;
    logic [cdp_pkg::PERM_W-1:0]        r_quo;
    logic [cdp_pkg::STEP_W-1:0]        r_step;

    logic [cdp_pkg::CNT_W-1:0]         w_d;
    logic                              w_ge;
    logic                              w_done;
    logic                              w_last_k;

    assign w_d      = r_deltas[r_k];
    assign w_ge     = (r_rem >= r_div);
    assign w_done   = (r_step == cdp_pkg::STEP_W'(cdp_pkg::DIV_STEPS - 1));
    assign w_last_k = (r_k == cdp_pkg::LAST_ST);

    assign o_out_cpu   = r_cpu;
    assign o_out_state = r_k;
    assign o_permille  = r_quo;
    assign o_last      = w_last_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdp_pkg::BE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            cdp_pkg::BE_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    if (i_head.close) begin
                        n_state = cdp_pkg::BE_MUL;
                    end
                end
            end
            cdp_pkg::BE_MUL: begin
                n_state = cdp_pkg::BE_ADD;
            end
            cdp_pkg::BE_ADD: begin
                n_state = r_sat ? cdp_pkg::BE_OUT : cdp_pkg::BE_DIV;
            end
            cdp_pkg::BE_DIV: begin
                if (w_done) begin
                    n_state = cdp_pkg::BE_OUT;
                end
            end
            cdp_pkg::BE_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = w_last_k ? cdp_pkg::BE_IDLE : cdp_pkg::BE_MUL;
                end
            end
            default: begin
                n_state = cdp_pkg::BE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            cdp_pkg::BE_IDLE: begin
                if (!i_q_stat.empty) begin
                    r_deltas[i_head.st] <= i_head.diff;
                    if (i_head.close) begin
                        // Treat a zero total as one.
                        r_total <= (i_head.total == '0) ? cdp_pkg::CNT_W'(1) : i_head.total;
                        r_cpu   <= i_head.cpu;
                        r_k     <= '0;
                    end
                end
            end
            cdp_pkg::BE_MUL: begin
                r_sat <= (w_d >= r_total);
                // Scale by 1000 as 1024 - 16 - 8.
                r_rem <= (cdp_pkg::REM_W'(w_d) << 10)
                       - (cdp_pkg::REM_W'(w_d) << 4)
                       - (cdp_pkg::REM_W'(w_d) << 3);
                r_div <= cdp_pkg::REM_W'(r_total) << (cdp_pkg::DIV_STEPS - 1);
            end
            cdp_pkg::BE_ADD: begin
                // Add half the divisor for round half up.
                r_rem  <= r_rem + cdp_pkg::REM_W'(r_total >> 1);
                r_quo  <= r_sat ? cdp_pkg::PERM_W'(cdp_pkg::SCALE) : '0;
                r_step <= '0;
            end
            cdp_pkg::BE_DIV: begin
                if (w_ge) begin
                    r_rem <= r_rem - r_div;
                end
                r_quo  <= {r_quo[cdp_pkg::PERM_W-2:0], w_ge};
                r_div  <= r_div >> 1;
                r_step <= r_step + 1'b1;
            end
            cdp_pkg::BE_OUT: begin
                if (!i_out_stall && !w_last_k) begin
                    r_k <= r_k + 1'b1;
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/counter_delta_permille.sv */
// Top level of the per-CPU state counter share block, in tenths of a percent.
//
// Input channel (i_in_valid / o_in_stall): one transaction carries one 64-bit
// free-running tick count for one state of one CPU. States arrive in order
// 0 to NUM_STATES-1; the transaction for the last state closes the run.
// Samples with a CPU or state index out of range are taken and dropped.
// Output channel (o_out_valid / i_out_stall): one transaction per state when
// a run closes, state 0 first, o_last high on the final state's share.
// Sequencing: the front end takes a new sample only once the last one has
// passed accept, previous-count memory read and difference, and queue push
// (an out-of-range sample skips the push). The back end pops each queued sample
// while idle and, on a closing sample, works through each share as multiply,
// round, 10 divider steps and output, or multiply, round and output for a
// share that saturates at full scale; the 10-step divider sets the pace.
// Reset clears the previous-count valid bits, the run total, the queue and
// both state machines at once; no clearing pass is needed.
// A receiver stall holds the current share on the outputs; the front end
// keeps taking samples until the queue fills, then holds o_in_stall high until
// the back end pops an entry.
`timescale 1ns / 1ps
`default_nettype none
module counter_delta_permille (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [cdp_pkg::CPU_W-1:0]     i_cpu_index,
    input  wire logic [cdp_pkg::ST_W-1:0]      i_state_index,
    input  wire logic [cdp_pkg::CNT_W-1:0]     i_count_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [cdp_pkg::CPU_W-1:0]          o_out_cpu,
    output logic [cdp_pkg::ST_W-1:0]           o_out_state,
    output logic [cdp_pkg::PERM_W-1:0]         o_permille,
    output logic                               o_last
);

    // Classified samples, front to back.
    cdp_pkg::t_entry    w_push_entry;
    cdp_pkg::t_entry    w_head;
    cdp_pkg::t_q_stat   w_q_stat;
    logic               w_push;
    logic               w_pop;

    // Front: difference against the stored count, update the run total.
    cdp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cpu_index   (i_cpu_index),
        .i_state_index (i_state_index),
        .i_count_value (i_count_value),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_entry       (w_push_entry)
    );

    // Decouple the two halves so each can stall on its own.
    cdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // Back: keep the deltas, divide out each share when a run closes.
    cdp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (w_q_stat),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_cpu   (o_out_cpu),
        .o_out_state (o_out_state),
        .o_permille  (o_permille),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

/* hw/rtl/cdp_checker.sv */
// Port-level checks on the counter delta permille block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module cdp_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic [cdp_pkg::CPU_W-1:0]     i_out_cpu,
    input  wire logic [cdp_pkg::ST_W-1:0]      i_out_state,
    input  wire logic [cdp_pkg::PERM_W-1:0]    i_permille,
    input  wire logic                          i_last
);

    a_perm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_permille <= cdp_pkg::PERM_W'(cdp_pkg::SCALE)))
        else $error("share above full scale");

    a_last_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last == (i_out_state == cdp_pkg::LAST_ST)))
        else $error("last flag does not match final state");

    a_state_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_stall && !i_last) |=>
            (!i_out_valid || (i_out_state == $past(i_out_state) + 1'b1)))
        else $error("shares out of state order");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=>
            (i_out_valid && $stable(i_permille) && $stable(i_out_cpu)
             && $stable(i_out_state)))
        else $error("stalled share changed");

endmodule

bind counter_delta_permille cdp_checker u_cdp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_cpu   (o_out_cpu),
    .i_out_state (o_out_state),
    .i_permille  (o_permille),
    .i_last      (o_last)
);
`default_nettype wire

/* sim/counter_delta_permille_tb.sv */
// Testbench for counter_delta_permille: directed and random counter samples checked per share.
`timescale 1ns / 1ps
module counter_delta_permille_tb;

    localparam int              CPU_W      = cdp_pkg::CPU_W;
    localparam int              ST_W       = cdp_pkg::ST_W;
    localparam int              CNT_W      = cdp_pkg::CNT_W;
    localparam int              PERM_W     = cdp_pkg::PERM_W;
    localparam int              SLOT_N     = cdp_pkg::SLOT_N;
    localparam int              SLOT_W     = cdp_pkg::SLOT_W;
    localparam int              NUM_STATES = cdp_pkg::NUM_STATES;
    localparam int              NUM_CPUS   = cdp_pkg::NUM_CPUS;
    localparam int              SCALE      = cdp_pkg::SCALE;
    localparam logic [ST_W-1:0] LAST_ST    = cdp_pkg::LAST_ST;

    // Worst case is far below this: every sample closing a run, five shares
    // each with a full divide plus a receiver stall per share.
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_SAMPLES = 85;
    localparam int DRAIN_CYCLES   = 100;

    localparam logic [CNT_W-1:0]  ALL_ONES   = '1;
    localparam logic [CNT_W-1:0]  MSB_ONLY   = {1'b1, {(CNT_W - 1){1'b0}}};
    localparam logic [PERM_W-1:0] FULL_SHARE = PERM_W'(SCALE);
    localparam int                ST_MAX     = (1 << ST_W) - 1;

    // One share as it leaves the block.
    typedef struct packed {
        logic [CPU_W-1:0]  cpu;
        logic [ST_W-1:0]   st;
        logic [PERM_W-1:0] permille;
        logic              last;
    } t_share;

    // Mirrors the block: per-CPU previous counts, per-state deltas and the
    // running total, plus the shares still owed by the block in order.
    class permille_scoreboard;
        bit [CNT_W-1:0] prev_count [SLOT_N];
        bit [CNT_W-1:0] state_delta [NUM_STATES];
        bit [CNT_W-1:0] run_total;
        t_share         expected_shares [$];
        int             errors;

        function void note_sample(logic [CPU_W-1:0] cpu, logic [ST_W-1:0] st,
                                  logic [CNT_W-1:0] value);
            logic [SLOT_W-1:0]  slot;
            int                 k;
            bit [CNT_W-1:0]     diff;
            bit [CNT_W-1:0]     divisor;
            bit [2*CNT_W-1:0]   scaled;
            t_share             share;
            // drop samples whose index is out of range, no state change
            if (cpu >= NUM_CPUS || st >= NUM_STATES) return;
            slot = SLOT_W'(cpu) * SLOT_W'(NUM_STATES) + SLOT_W'(st);
            diff = value - prev_count[slot];
            prev_count[slot] = value;
            state_delta[st] = diff;
            // state 0 restarts the total, every other state adds to it
            run_total = (st == 0) ? diff : run_total + diff;
            if (st != LAST_ST) return;
            divisor = (run_total == 0) ? 1 : run_total;
            for (k = 0; k < NUM_STATES; k++) begin
                if (state_delta[ST_W'(k)] >= divisor) begin
                    // wrapped sum or stale delta: saturate
                    share.permille = FULL_SHARE;
                end else begin
                    // exact 128-bit numerator, round half up
                    scaled = {{CNT_W{1'b0}}, state_delta[ST_W'(k)]} * SCALE + (divisor >> 1);
                    scaled = scaled / {{CNT_W{1'b0}}, divisor};
                    share.permille = (scaled > SCALE) ? FULL_SHARE : scaled[PERM_W-1:0];
                end
                share.cpu  = cpu;
                share.st   = ST_W'(k);
                share.last = (k == NUM_STATES - 1);
                expected_shares.push_back(share);
            end
        endfunction

        function void check_share(t_share got);
            t_share want;
            if (expected_shares.size() == 0) begin
                $display("%0t: unexpected share, actual cpu %0d state %0d permille %0d last %0d",
                         $time, got.cpu, got.st, got.permille, got.last);
                errors++;
                return;
            end
            want = expected_shares.pop_front();
            if (got !== want) begin
                $display("%0t: share mismatch, expected cpu %0d state %0d permille %0d last %0d",
                         $time, want.cpu, want.st, want.permille, want.last);
                $display("%0t:                 actual cpu %0d state %0d permille %0d last %0d",
                         $time, got.cpu, got.st, got.permille, got.last);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_in_valid    = 1'b0;
    logic              o_in_stall;
    logic [CPU_W-1:0]  i_cpu_index   = '0;
    logic [ST_W-1:0]   i_state_index = '0;
    logic [CNT_W-1:0]  i_count_value = '0;
    logic              o_out_valid;
    logic              i_out_stall   = 1'b0;
    logic [CPU_W-1:0]  o_out_cpu;
    logic [ST_W-1:0]   o_out_state;
    logic [PERM_W-1:0] o_permille;
    logic              o_last;

    // When set, both sides stop idling so back-to-back transactions occur.
    bit                 steady = 1'b0;
    int unsigned        cycles = 0;
    permille_scoreboard sb;

    // Opening runs: the first one writes every delta entry so no later run
    // ever reads an unwritten delta.
    //   run 0, CPU 0: total 2000, state 0 sits exactly on a half step
    //   run 1, CPU 7: two deltas of 2^63 wrap the total to zero -> saturate
    //   run 2, CPU 0: same counts again, all deltas and the total are zero
    logic [CNT_W-1:0] opening_counts [3][NUM_STATES] = '{
        '{64'd1, 64'd1999, 64'd0, 64'd0, 64'd0},
        '{MSB_ONLY, MSB_ONLY, 64'd0, 64'd0, 64'd0},
        '{64'd1, 64'd1999, 64'd0, 64'd0, 64'd0}
    };
    logic [CPU_W-1:0] opening_cpu [3] = '{3'd0, 3'd7, 3'd0};

    counter_delta_permille uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cpu_index   (i_cpu_index),
        .i_state_index (i_state_index),
        .i_count_value (i_count_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_cpu     (o_out_cpu),
        .o_out_state   (o_out_state),
        .o_permille    (o_permille),
        .o_last        (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a missing share ends here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Drive one sample. Called at a rising edge; returns at the edge where
    // the transaction is taken. With no gap, valid stays high and only the
    // payload advances, so valid never gets two updates in one step.
    task automatic send_sample(input logic [CPU_W-1:0] cpu, input logic [ST_W-1:0] st,
                               input logic [CNT_W-1:0] value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cpu_index   <= cpu;
        i_state_index <= st;
        i_count_value <= value;
        // hold the payload until an edge with stall low
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(cpu, st, value);
    endtask

    // Receiver: before each share, raise the stall unless the random hold is zero,
    // then take the next share at the first edge with valid high and stall low.
    initial begin : share_sink
        int     hold;
        t_share got;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            hold = steady ? 0 : $urandom_range(0, 4);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            got = {o_out_cpu, o_out_state, o_permille, o_last};
            sb.check_share(got);
        end
    end

    initial begin : stimulus
        logic [CPU_W-1:0] cpu;
        logic [CNT_W-1:0] delta;
        int               sent;
        int               kind;
        int               run;
        int               st;
        int               first_st;
        int               skip_st;
        int               switch_st;
        sb = new;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---
        for (run = 0; run < 3; run++) begin
            for (st = 0; st < NUM_STATES; st++) begin
                send_sample(opening_cpu[2'(run)], ST_W'(st),
                            opening_counts[2'(run)][ST_W'(st)]);
            end
        end
        // out-of-range state indexes: taken and dropped
        for (st = NUM_STATES; st <= ST_MAX; st++) begin
            send_sample(CPU_W'($urandom), ST_W'(st), {$urandom, $urandom});
        end
        // states 1 to 3 skipped: stale deltas, total of two all-ones deltas
        // wraps below each delta, so both saturate
        send_sample(3'd1, ST_W'(0), ALL_ONES);
        send_sample(3'd1, LAST_ST, ALL_ONES);
        // CPU changes mid-run; the closing CPU is reported
        for (st = 0; st < NUM_STATES; st++) begin
            send_sample((st < 3) ? 3'd2 : 3'd3, ST_W'(st), {$urandom, $urandom});
        end

        // --- random part ---
        // Mostly well-formed runs with deltas of mixed size, plus runs with a
        // skipped state, a CPU switch, a late start, and out-of-range noise.
        sent = 0;
        while (sent < RANDOM_SAMPLES) begin
            kind   = $urandom_range(0, 19);
            steady = ($urandom_range(0, 4) == 0);
            cpu    = CPU_W'($urandom_range(0, NUM_CPUS - 1));
            if (kind == 0) begin
                send_sample(cpu, ST_W'($urandom_range(NUM_STATES, ST_MAX)), {$urandom, $urandom});
            end else begin
                skip_st   = (kind == 1) ? $urandom_range(0, NUM_STATES - 1) : -1;
                switch_st = (kind == 2) ? $urandom_range(1, NUM_STATES - 1) : -1;
                first_st  = (kind == 3) ? $urandom_range(1, NUM_STATES - 1) : 0;
                for (st = first_st; st < NUM_STATES; st++) begin
                    if (st == switch_st) cpu = CPU_W'($urandom_range(0, NUM_CPUS - 1));
                    if (st != skip_st) begin
                        case ($urandom_range(0, 9))
                            0:             delta = '0;
                            1, 2, 3, 4, 5: delta = CNT_W'($urandom_range(0, 5000));
                            6, 7:          delta = CNT_W'($urandom);
                            default:       delta = {$urandom, $urandom};
                        endcase
                        send_sample(cpu, ST_W'(st),
                                    sb.prev_count[SLOT_W'(cpu) * SLOT_W'(NUM_STATES)
                                                  + SLOT_W'(st)] + delta);
                        sent++;
                    end
                end
            end
        end
        i_in_valid <= 1'b0;
        steady = 1'b0;

        // drain: every owed share must arrive, then let the back end settle
        while (sb.expected_shares.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
